>>> src/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue.
// Each check samples on the rising edge of i_clk and is disabled during reset.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_NOW(label, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/spq_pkg.sv
package spq_pkg;

    // Store geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PRIO_W      = 2;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((VALUE_WIDTH + PRIO_W + 7) / 8) * 8;
    localparam int OUT_BITS   = VALUE_WIDTH + 1 + 2 + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command carried in tuser
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    load;    // capture the incoming item
        logic    exec;    // update the store and load the result register
        logic    push;    // insert the captured entry
        logic    pop;     // remove the head entry
        t_status status;  // status code of this item
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pop_req;    // captured item is a pop
        logic full;
        logic empty;
    } t_dp_stat;

    // Result item, head_value in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]     entry_count;
        t_status                step_status;
        logic                   queue_empty;
        logic [VALUE_WIDTH-1:0] head_value;
    } t_out_item;

endpackage

>>> src/spq_ctrl.sv
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    // Take an item only when the result register is free or draining now
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = o_s_tready && i_s_tvalid;
    assign o_m_tvalid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_m_tready;
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.status = spq_pkg::ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                if (i_stat.pop_req) begin
                    o_cmd.pop    = !i_stat.empty;
                    o_cmd.status = i_stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
                end else begin
                    o_cmd.push   = !i_stat.full;
                    o_cmd.status = i_stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/spq_datapath.sv
module spq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [spq_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tuser,
    input  spq_pkg::t_dp_cmd                    i_cmd,
    output spq_pkg::t_dp_stat                   o_stat,
    output logic [spq_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    // Captured item
    logic                            r_in_pop;
    logic [spq_pkg::VALUE_WIDTH-1:0] r_in_val;
    logic [spq_pkg::PRIO_W-1:0]      r_in_prio;

    // Cell row, head at cell 0
    logic [spq_pkg::VALUE_WIDTH-1:0] r_val  [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0]      r_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::COUNT_W-1:0]     r_count;
    logic [spq_pkg::VALUE_WIDTH-1:0] n_val  [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0]      n_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::COUNT_W-1:0]     n_count;

    // Cell holds an entry that stays ahead of the new one
    logic [spq_pkg::QUEUE_DEPTH-1:0] keep;

    spq_pkg::t_out_item r_out;
    spq_pkg::t_out_item n_out;

    assign o_stat.pop_req = r_in_pop;
    assign o_stat.full    = (r_count == spq_pkg::COUNT_W'(spq_pkg::QUEUE_DEPTH));
    assign o_stat.empty   = (r_count == '0);
    assign o_m_tdata      = spq_pkg::OUT_DATA_W'(r_out);

    // Per-cell compare against the captured priority
    always_comb begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
            keep[i] = (spq_pkg::COUNT_W'(i) < r_count) && (r_prio[i] >= r_in_prio);
        end
    end

    // Cell update: hold, take the new entry, or shift from a neighbour
    always_comb begin
        n_val   = r_val;
        n_prio  = r_prio;
        n_count = r_count;
        if (i_cmd.push) begin
            if (!keep[0]) begin
                n_val[0]  = r_in_val;
                n_prio[0] = r_in_prio;
            end
            for (int i = 1; i < spq_pkg::QUEUE_DEPTH; i++) begin
                if (!keep[i]) begin
                    if (keep[i-1]) begin
                        n_val[i]  = r_in_val;
                        n_prio[i] = r_in_prio;
                    end else begin
                        n_val[i]  = r_val[i-1];
                        n_prio[i] = r_prio[i-1];
                    end
                end
            end
            n_count = r_count + spq_pkg::COUNT_W'(1);
        end else if (i_cmd.pop) begin
            for (int i = 0; i < spq_pkg::QUEUE_DEPTH - 1; i++) begin
                n_val[i]  = r_val[i+1];
                n_prio[i] = r_prio[i+1];
            end
            n_count = r_count - spq_pkg::COUNT_W'(1);
        end
    end

    // Result describes the store after the update
    always_comb begin
        n_out.head_value  = (n_count != '0) ? n_val[0] : '0;
        n_out.queue_empty = (n_count == '0);
        n_out.step_status = i_cmd.status;
        n_out.entry_count = n_count;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_pop  <= (spq_pkg::t_cmd'(i_s_tuser) == spq_pkg::CMD_POP);
            r_in_val  <= i_s_tdata[spq_pkg::VALUE_WIDTH-1:0];
            r_in_prio <= i_s_tdata[spq_pkg::VALUE_WIDTH +: spq_pkg::PRIO_W];
        end
        if (i_cmd.exec) begin
            r_val  <= n_val;
            r_prio <= n_prio;
            r_out  <= n_out;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

endmodule

>>> src/sorted_priority_queue.sv
// Sorted priority queue: a row of 16 cells kept in priority order, urgent (3)
// at the head, first in first out within a level. An item carries a command in
// tuser (0 push, 1 pop) and the value and priority level in tdata; each item
// gives exactly one result with the head value (zero when empty), an empty
// flag, a status (0 done, 1 push rejected full, 2 pop rejected empty) and the
// entry count, all after the step. An item is first captured into the input
// registers; then, in the execute state, every cell of the row holds, loads the
// new entry or shifts from its neighbour at once. A new item is taken while the
// previous result is being read out, but not while one is still being executed.
// No clearing pass follows reset.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] data_value, [33:32] priority_level, rest zero
    input  logic [spq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] head_value, [32] queue_empty, [34:33] step_status, [39:35] entry_count
    output logic [spq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    spq_pkg::t_dp_cmd  cmd;
    spq_pkg::t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spq_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_s_tuser (s_axis_tuser),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_m_tdata (m_axis_tdata)
    );

    // A waiting result is never overwritten by a new item
    `SPQ_ASSERT_NOW(a_no_overrun, s_axis_tready, (!m_axis_tvalid || m_axis_tready), "input taken over a pending result")

    // One item at a time: no accept in the cycle after an accept
    `SPQ_ASSERT_NEXT(a_one_in_flight, (s_axis_tvalid && s_axis_tready), !s_axis_tready, "second item accepted while busy")

    // Count never exceeds the depth
    `SPQ_ASSERT_NOW(a_count_range, m_axis_tvalid, (m_axis_tdata[39:35] <= 5'd16), "entry count out of range")

    // Empty flag agrees with the count
    `SPQ_ASSERT_NOW(a_empty_flag, m_axis_tvalid, (m_axis_tdata[32] == (m_axis_tdata[39:35] == 5'd0)), "empty flag disagrees with count")

endmodule

>>> tb/sv/sorted_priority_queue_test.sv
module sorted_priority_queue_test;

    // Cycles with no handshake on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    // One command waiting to be sent; gap is idle cycles after it, hold waits for a drain
    typedef struct {
        spq_pkg::t_cmd                   cmd;
        logic [spq_pkg::VALUE_WIDTH-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]      level;
        int                              gap;
        bit                              hold;
    } t_command;

    // One stored entry of the shadow queue
    typedef struct {
        logic [spq_pkg::VALUE_WIDTH-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]      level;
    } t_entry;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [31:0] data_value, [33:32] priority_level, rest zero
    logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] command
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [31:0] head_value, [32] queue_empty, [34:33] step_status, [39:35] entry_count
    logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    t_command           commands_to_send[$];
    t_entry             held_entries[$];
    spq_pkg::t_out_item awaited_results[$];
    t_command           in_flight;

    int tx_gap;
    int rx_stall;
    int rx_calm;
    int idle_cycles;
    int error_count;
    int n_push, n_pop, n_full, n_empty, n_checked;

    sorted_priority_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Shadow of the sorted store: applies one command, returns the result it gives
    function automatic spq_pkg::t_out_item apply_queue_command(t_command c);
        spq_pkg::t_out_item r;
        t_entry             e;
        int                 pos;
        r.step_status = spq_pkg::ST_DONE;
        if (c.cmd == spq_pkg::CMD_PUSH) begin
            if (held_entries.size() >= spq_pkg::QUEUE_DEPTH) begin
                r.step_status = spq_pkg::ST_FULL;
                n_full++;
            end else begin
                // new entry goes behind every entry of equal or higher level
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].level < c.level)
                    pos--;
                e.value = c.value;
                e.level = c.level;
                held_entries.insert(pos, e);
                n_push++;
            end
        end else begin
            if (held_entries.size() == 0) begin
                r.step_status = spq_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                void'(held_entries.pop_front());
                n_pop++;
            end
        end
        if (held_entries.size() > 0) begin
            r.head_value  = held_entries[0].value;
            r.queue_empty = 1'b0;
        end else begin
            r.head_value  = '0;
            r.queue_empty = 1'b1;
        end
        r.entry_count = spq_pkg::COUNT_W'(held_entries.size());
        return r;
    endfunction

    task automatic add_command(spq_pkg::t_cmd cmd, logic [spq_pkg::VALUE_WIDTH-1:0] value,
                               logic [spq_pkg::PRIO_W-1:0] level, int gap, bit hold);
        t_command c;
        c.cmd   = cmd;
        c.value = value;
        c.level = level;
        c.gap   = gap;
        c.hold  = hold;
        commands_to_send.push_back(c);
    endtask

    // Sender: offers queued items, records the expected result on acceptance
    always @(posedge i_clk) begin : tx_side
        bit                            busy;
        logic [spq_pkg::IN_DATA_W-1:0] word;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(apply_queue_command(in_flight));
                busy = 1'b0;
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (commands_to_send.size() > 0 &&
                             !(commands_to_send[0].hold && awaited_results.size() > 0)) begin
                    in_flight = commands_to_send.pop_front();
                    tx_gap = in_flight.gap;
                    busy = 1'b1;
                    word = '0;
                    word[spq_pkg::VALUE_WIDTH-1:0]              = in_flight.value;
                    word[spq_pkg::VALUE_WIDTH+:spq_pkg::PRIO_W] = in_flight.level;
                    s_axis_tdata <= word;
                    s_axis_tuser <= in_flight.cmd;
                end
            end
            s_axis_tvalid <= busy;
        end
    end

    // Receiver: random back-pressure, checks each result against the oldest expectation
    always @(posedge i_clk) begin : rx_side
        spq_pkg::t_out_item got;
        spq_pkg::t_out_item want;
        int                 roll;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
            rx_calm  = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(spq_pkg::t_out_item)-1:0];
                if (awaited_results.size() == 0) begin
                    $error("result with nothing expected: tdata %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    n_checked++;
                    if (got.head_value !== want.head_value) begin
                        $error("head_value: expected %h, got %h", want.head_value,
                               got.head_value);
                        error_count++;
                    end
                    if (got.queue_empty !== want.queue_empty) begin
                        $error("queue_empty: expected %b, got %b", want.queue_empty,
                               got.queue_empty);
                        error_count++;
                    end
                    if (got.step_status !== want.step_status) begin
                        $error("step_status: expected %0d, got %0d", want.step_status,
                               got.step_status);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               got.entry_count);
                        error_count++;
                    end
                end
            end
            if (rx_calm > 0) begin
                rx_calm--;
                m_axis_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    rx_calm = $urandom_range(40, 150);
                else if (roll >= 60)
                    rx_stall = pick_gap();
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int                              seg_len;
        int                              mode;
        int                              push_pct;
        int                              roll;
        int                              n_random;
        bit                              calm;
        spq_pkg::t_cmd                   cmd;
        logic [spq_pkg::VALUE_WIDTH-1:0] value;
        idle_cycles = 0;
        error_count = 0;
        n_push = 0;
        n_pop = 0;
        n_full = 0;
        n_empty = 0;
        n_checked = 0;

        // Pop from an empty store, with the ignored fields at their maximum
        add_command(spq_pkg::CMD_POP, {spq_pkg::VALUE_WIDTH{1'b1}}, 2'd3, 0, 1'b0);
        // Fill the store; levels interleave so inserts land mid-row and ties keep order
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
            if (i == 0)
                value = '0;
            else if (i == 1)
                value = {spq_pkg::VALUE_WIDTH{1'b1}};
            else
                value = $urandom;
            add_command(spq_pkg::CMD_PUSH, value, spq_pkg::PRIO_W'((i * 3) % 4),
                        (i % 5 == 4) ? 3 : 0, 1'b0);
        end
        // Push into a full store
        add_command(spq_pkg::CMD_PUSH, 32'hA5A5_A5A5, 2'd3, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            add_command(spq_pkg::CMD_POP, $urandom, spq_pkg::PRIO_W'(i), 0, 1'b0);

        // Random part: runs biased toward filling, draining or neither
        n_random = 0;
        while (n_random < 400) begin
            seg_len = $urandom_range(8, 40);
            mode    = $urandom_range(0, 2);
            calm    = ($urandom_range(0, 3) == 0);
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (int k = 0; k < seg_len; k++) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? spq_pkg::CMD_PUSH
                                                         : spq_pkg::CMD_POP;
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    value = '0;
                else if (roll == 1)
                    value = {spq_pkg::VALUE_WIDTH{1'b1}};
                else
                    value = $urandom;
                // first random item always waits for a full drain
                add_command(cmd, value, spq_pkg::PRIO_W'($urandom_range(0, 3)),
                            calm ? 0 : pick_gap(),
                            (n_random == 0) || ($urandom_range(0, 59) == 0));
                n_random++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (commands_to_send.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results: %0d pushes stored, %0d pops done,", n_checked,
                 n_push, n_pop);
        $display("%0d pushes refused on full, %0d pops refused on empty.", n_full, n_empty);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_test.sv
